// ===== hdl/mhpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  // Heap geometry. Positions are one-based, 1..CAPACITY.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [STATUS_W-1:0]     status_t;

  // Operation codes of the input word.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Status codes of the result word.
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_EMPTY = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  // Result word passed from the sequencer to the output stage.
  typedef struct packed {
    val_t                 top_value;
    logic [COUNT_W-1:0]   count;
    status_t              status;
  } res_t;

  // Memory address of a one-based heap position.
  function automatic addr_t pos_to_addr(input idx_t pos);
    idx_t p;
    p = pos - idx_t'(1);
    return p[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mhpq_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhpq_cmp
  import mhpq_pkg::*;
(
  input  val_t a,
  input  val_t b,
  output logic a_gt_b
);

  // Shared signed magnitude compare used by every sift step.
  assign a_gt_b = (a > b);

endmodule

`default_nettype wire

// ===== hdl/mhpq_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mhpq_core
  import mhpq_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  cmd_valid,
  output logic cmd_ready,
  input  wire  cmd_op,
  input  val_t cmd_value,
  output logic res_valid,
  input  wire  res_ready,
  output res_t res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_I_CHK,
    S_I_CMP,
    S_D_LOAD,
    S_D_CHK,
    S_D_RL,
    S_D_RR,
    S_D_CMP,
    S_DONE
  } state_t;

  state_t  state_r;
  idx_t    pos_r;
  idx_t    cnt_r;
  idx_t    pick_idx_r;
  val_t    cur_r;
  val_t    lval_r;
  val_t    pick_r;
  val_t    top_r;
  status_t status_r;

  // Heap storage: one write and one registered read per cycle.
  val_t mem [CAPACITY];
  val_t rdata_r;

  logic         re_c;
  addr_t        raddr_c;
  logic         we_c;
  idx_t         widx_c;
  val_t         wdata_c;
  logic [IDX_W:0] left_c;
  idx_t         parent_c;
  val_t         cmp_a_c;
  val_t         cmp_b_c;
  logic         gt_c;
  logic         pos_is_root_c;
  logic         no_child_c;
  logic         has_right_c;

  // Child and parent positions of the current hole.
  assign left_c        = {pos_r, 1'b0};
  assign parent_c      = pos_r >> 1;
  assign pos_is_root_c = (pos_r == idx_t'(1));
  assign no_child_c    = (left_c > {1'b0, cnt_r});
  assign has_right_c   = (left_c < {1'b0, cnt_r});

  // Operand selection for the shared compare unit.
  always_comb begin
    unique case (state_r)
      S_D_RR: begin
        cmp_a_c = rdata_r;
        cmp_b_c = lval_r;
      end
      S_D_CMP: begin
        cmp_a_c = pick_r;
        cmp_b_c = cur_r;
      end
      default: begin
        cmp_a_c = cur_r;
        cmp_b_c = rdata_r;
      end
    endcase
  end

  mhpq_cmp u_cmp (
    .a      (cmp_a_c),
    .b      (cmp_b_c),
    .a_gt_b (gt_c)
  );

  // Memory port control for each sequencer step.
  always_comb begin
    re_c    = 1'b0;
    raddr_c = pos_to_addr(cnt_r);
    we_c    = 1'b0;
    widx_c  = pos_r;
    wdata_c = cur_r;
    unique case (state_r)
      S_IDLE: begin
        re_c    = cmd_valid && (cmd_op == OP_DELETE) && (cnt_r != '0);
        raddr_c = pos_to_addr(cnt_r);
      end
      S_I_CHK: begin
        if (pos_is_root_c) begin
          we_c = 1'b1;
        end else begin
          re_c    = 1'b1;
          raddr_c = pos_to_addr(parent_c);
        end
      end
      S_I_CMP: begin
        we_c    = 1'b1;
        wdata_c = gt_c ? rdata_r : cur_r;
      end
      S_D_CHK: begin
        if (no_child_c) begin
          we_c = 1'b1;
        end else begin
          re_c    = 1'b1;
          raddr_c = pos_to_addr(left_c[IDX_W-1:0]);
        end
      end
      S_D_RL: begin
        re_c    = has_right_c;
        raddr_c = pos_to_addr(left_c[IDX_W-1:0] + idx_t'(1));
      end
      S_D_CMP: begin
        we_c    = 1'b1;
        wdata_c = gt_c ? pick_r : cur_r;
      end
      default: begin
        re_c = 1'b0;
      end
    endcase
  end

  // Storage array.
  always_ff @(posedge clk) begin
    if (we_c) begin
      mem[pos_to_addr(widx_c)] <= wdata_c;
    end
    if (re_c) begin
      rdata_r <= mem[raddr_c];
    end
  end

  // Sequencer and its registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      pos_r    <= '0;
      status_r <= STATUS_OK;
    end else begin
      // Keep a copy of the root so the result needs no extra read.
      if (we_c && (widx_c == idx_t'(1))) begin
        top_r <= wdata_c;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            status_r <= STATUS_OK;
            if (cmd_op == OP_INSERT) begin
              if (cnt_r == idx_t'(CAPACITY)) begin
                status_r <= STATUS_FULL;
                state_r  <= S_DONE;
              end else begin
                cnt_r   <= cnt_r + idx_t'(1);
                pos_r   <= cnt_r + idx_t'(1);
                cur_r   <= cmd_value;
                state_r <= S_I_CHK;
              end
            end else begin
              if (cnt_r == '0) begin
                status_r <= STATUS_EMPTY;
                state_r  <= S_DONE;
              end else begin
                cnt_r   <= cnt_r - idx_t'(1);
                pos_r   <= idx_t'(1);
                state_r <= S_D_LOAD;
              end
            end
          end
        end
        S_I_CHK: begin
          state_r <= pos_is_root_c ? S_DONE : S_I_CMP;
        end
        S_I_CMP: begin
          if (gt_c) begin
            pos_r   <= parent_c;
            state_r <= S_I_CHK;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_D_LOAD: begin
          cur_r   <= rdata_r;
          state_r <= (cnt_r == '0) ? S_DONE : S_D_CHK;
        end
        S_D_CHK: begin
          state_r <= no_child_c ? S_DONE : S_D_RL;
        end
        S_D_RL: begin
          lval_r     <= rdata_r;
          pick_r     <= rdata_r;
          pick_idx_r <= left_c[IDX_W-1:0];
          state_r    <= has_right_c ? S_D_RR : S_D_CMP;
        end
        S_D_RR: begin
          // The right child wins only when strictly larger.
          if (gt_c) begin
            pick_r     <= rdata_r;
            pick_idx_r <= pick_idx_r + idx_t'(1);
          end
          state_r <= S_D_CMP;
        end
        S_D_CMP: begin
          if (gt_c) begin
            pos_r   <= pick_idx_r;
            state_r <= S_D_CHK;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Handshake and result word.
  assign cmd_ready     = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_DONE);
  assign res.top_value = (cnt_r != '0) ? top_r : '0;
  assign res.count     = COUNT_W'(cnt_r);
  assign res.status    = status_r;

endmodule

`default_nettype wire

// ===== hdl/max_heap_priority_queue.sv =====
// Insert sifts the new entry up; delete moves the last entry to the root and sifts
// it down; a rejected word on an empty or full heap goes straight to the result.
// Sift-up has a check and a compare state per level; sift-down a check, left read,
// a right read when a right child exists and a compare, on the single read port.
// One word is in work at a time; the next is accepted the cycle after the result
// enters the output register. Reset empties the heap; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 in_op,
  input  val_t                in_value,
  output logic                out_valid,
  input  wire                 out_ready,
  output val_t                out_top_value,
  output logic [COUNT_W-1:0]  out_count,
  output status_t             out_status
);

  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_r;
  logic out_valid_r;

  mhpq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_valid),
    .cmd_ready (in_ready),
    .cmd_op    (in_op),
    .cmd_value (in_value),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register; takes a new word when empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_top_value = out_r.top_value;
  assign out_count     = out_r.count;
  assign out_status    = out_r.status;

endmodule

`default_nettype wire
